// File: src/scs1_pkg.sv
// Shared types, constants and translation tables for the scan code set 1 key translator.
package scs1_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       data_ready;
  } in_word_t;

  typedef struct packed {
    logic [15:0] key_word;
    logic        key_valid;
    logic [7:0]  modifier_flags;
  } out_word_t;

  localparam logic [7:0] PREFIX_E0 = 8'hE0;
  localparam logic [7:0] PREFIX_E1 = 8'hE1;

  localparam logic [6:0] SC_ESC    = 7'h01;
  localparam logic [6:0] SC_BKSP   = 7'h0E;
  localparam logic [6:0] SC_TAB    = 7'h0F;
  localparam logic [6:0] SC_ENTER  = 7'h1C;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_SPACE  = 7'h39;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_NUM    = 7'h45;
  localparam logic [6:0] SC_SCROLL = 7'h46;
  localparam logic [6:0] SC_INSERT = 7'h52;

  localparam logic [7:0] F_RSHIFT = 8'h01;
  localparam logic [7:0] F_LSHIFT = 8'h02;
  localparam logic [7:0] F_CTRL   = 8'h04;
  localparam logic [7:0] F_ALT    = 8'h08;
  localparam logic [7:0] F_SCROLL = 8'h10;
  localparam logic [7:0] F_NUM    = 8'h20;
  localparam logic [7:0] F_CAPS   = 8'h40;
  localparam logic [7:0] F_INS    = 8'h80;

  localparam int unsigned TAB_LEN = 54;
  localparam logic [6:0]  TAB_LIMIT = 7'(TAB_LEN);

  localparam logic [7:0] LOWER_TAB [TAB_LEN] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F
  };

  localparam logic [7:0] UPPER_TAB [TAB_LEN] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F
  };

endpackage

// File: src/scancode_set1_key_translator_unit.sv
// Top level of the scan code set 1 to ASCII key translator.
//
// Input channel in_valid/in_ready/in_data carries one word per controller
// event: the raw scan code byte and its data-ready bit. Every accepted word
// produces exactly one result word on out_valid/out_ready/out_data, in order:
// the key word (scan code high, ASCII low), its store flag, and the modifier
// flag byte after that event.
// The input word is registered, decoded against the prefix and flag state,
// and the result is registered: a word passes the input register and then
// the result register before its result can be taken.
// One word per cycle is sustained while out_ready stays high; the prefix/flag
// registers are updated in the same cycle the result register is loaded.
// Reset clears both pipeline valids, the prefix byte and the flag byte.
// When the receiver stalls, the result register holds and the input
// register keeps one more word; in_ready drops only when both are full.
module scancode_set1_key_translator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scs1_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scs1_pkg::out_word_t  out_data
);
  import scs1_pkg::*;

  logic      in_v_r;
  in_word_t  in_d_r;
  logic      out_v_r;
  out_word_t out_d_r;
  out_word_t res;
  logic      res_can;
  logic      adv;

  assign res_can  = !out_v_r || out_ready;
  assign adv      = in_v_r && res_can;
  assign in_ready = !in_v_r || res_can;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
  end

  scs1_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_d_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_can) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_word_zero_when_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_valid |-> out_data.key_word == 16'h0000)
    else $error("key word not zero without store flag");

  a_word_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_valid |->
      out_data.key_word[15] == 1'b0 && out_data.key_word[14:8] != 7'h00)
    else $error("stored key word has bad scan code");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled with room in pipeline");

endmodule

// File: src/scs1_ascii.sv
// Scan code to ASCII lookup with shift, caps and ctrl handling.
module scs1_ascii (
  input  logic [6:0] sc,
  input  logic [7:0] flags,
  output logic [7:0] ascii
);
  import scs1_pkg::*;

  logic       shifted;
  logic       caps;
  logic       ctrl;
  logic [5:0] idx;
  logic [7:0] ch;
  logic [7:0] ch_case;

  assign shifted = |(flags & (F_LSHIFT | F_RSHIFT));
  assign caps    = |(flags & F_CAPS);
  assign ctrl    = |(flags & F_CTRL);
  assign idx     = sc[5:0];

  always_comb begin
    ch = 8'h00;
    if (sc < TAB_LIMIT) begin
      ch = shifted ? UPPER_TAB[idx] : LOWER_TAB[idx];
    end
    ch_case = ch;
    if (caps) begin
      if (ch >= 8'h61 && ch <= 8'h7A) begin
        ch_case = ch - 8'h20;
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
        ch_case = ch + 8'h20;
      end
    end
  end

  always_comb begin
    if (ctrl && sc == SC_ENTER) begin
      ascii = 8'h0A;
    end else if (ctrl && sc == SC_BKSP) begin
      ascii = 8'h7F;
    end else begin
      unique case (sc)
        SC_ESC:   ascii = 8'h1B;
        SC_BKSP:  ascii = 8'h08;
        SC_TAB:   ascii = 8'h09;
        SC_ENTER: ascii = 8'h0D;
        SC_SPACE: ascii = 8'h20;
        default:  ascii = ch_case;
      endcase
    end
  end

endmodule

// File: src/scs1_decode.sv
// Prefix and modifier state with per-byte decode into a result word.
module scs1_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  scs1_pkg::in_word_t   item,
  output scs1_pkg::out_word_t  res
);
  import scs1_pkg::*;

  logic [7:0] prefix_r, prefix_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [6:0] sc;
  logic       release_key;
  logic [7:0] mask;
  logic       toggle;
  logic [7:0] ascii;
  logic       make_word;

  assign sc          = item.code_byte[6:0];
  assign release_key = item.code_byte[7];

  always_comb begin
    mask   = 8'h00;
    toggle = 1'b0;
    unique case (sc)
      SC_LSHIFT: mask = F_LSHIFT;
      SC_RSHIFT: mask = F_RSHIFT;
      SC_CTRL:   mask = F_CTRL;
      SC_ALT:    mask = F_ALT;
      SC_CAPS:   begin mask = F_CAPS;   toggle = 1'b1; end
      SC_NUM:    begin mask = F_NUM;    toggle = 1'b1; end
      SC_SCROLL: begin mask = F_SCROLL; toggle = 1'b1; end
      default:   mask = 8'h00;
    endcase
  end

  always_comb begin
    prefix_nxt = prefix_r;
    flag_nxt   = flag_r;
    make_word  = 1'b0;
    if (item.data_ready) begin
      if (item.code_byte == PREFIX_E0 || item.code_byte == PREFIX_E1) begin
        prefix_nxt = item.code_byte;
      end else if (sc != 7'h00) begin
        prefix_nxt = 8'h00;
        if (mask != 8'h00) begin
          if (toggle) begin
            if (!release_key) flag_nxt = flag_r ^ mask;
          end else if (!release_key) begin
            flag_nxt = flag_r | mask;
          end else begin
            flag_nxt = flag_r & ~mask;
          end
        end else begin
          if (sc == SC_INSERT && !release_key && prefix_r == 8'h00) begin
            flag_nxt = flag_r ^ F_INS;
          end
          make_word = !release_key;
        end
      end
    end
  end

  scs1_ascii u_ascii (
    .sc    (sc),
    .flags (flag_nxt),
    .ascii (ascii)
  );

  always_comb begin
    res.key_valid      = make_word;
    res.modifier_flags = flag_nxt;
    res.key_word       = 16'h0000;
    if (make_word) begin
      res.key_word = {1'b0, sc, (prefix_r == PREFIX_E0) ? 8'h00 : ascii};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 8'h00;
      flag_r   <= 8'h00;
    end else if (adv) begin
      prefix_r <= prefix_nxt;
      flag_r   <= flag_nxt;
    end
  end

endmodule
